>>> hw/rtl/slil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slil_pkg: shared types for the ordered list unit
// Command codes, beat payload types and the per-cell control word.
// ----------------------------------------------------------------------------
package slil_pkg;

   localparam int VALUE_W     = 32;
   localparam int POS_W       = 6;
   localparam int COUNT_OUT_W = 7;

   typedef enum logic [1:0] {
      CMD_INSERT_AT     = 2'd0,
      CMD_INSERT_SORTED = 2'd1,
      CMD_REMOVE        = 2'd2,
      CMD_READ          = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic signed [VALUE_W-1:0]  value;
      logic [POS_W-1:0]           position;
   } req_type;

   typedef struct packed {
      logic                       ok;
      logic signed [VALUE_W-1:0]  read_value;
      logic [POS_W-1:0]           index_used;
      logic [COUNT_OUT_W-1:0]     count;
      logic                       is_empty;
      logic                       is_full;
   } rsp_type;

   // broadcast to every cell: which shift to perform this cycle
   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctrl_type;

endpackage

>>> hw/rtl/slil_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slil_if: valid/ready channels
// Command channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface slil_req_if;
   logic              valid;
   logic              ready;
   slil_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface slil_rsp_if;
   logic              valid;
   logic              ready;
   slil_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/slil_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slil_cell: one list entry
// Holds one value, shifts up or down with its neighbours, and feeds the
// sorted-insert search with its own compare result.
// ----------------------------------------------------------------------------
module slil_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 7
) (
   input  logic                                    clock,
   input  slil_pkg::cell_ctrl_type                 ctrl,
   input  logic [CW-1:0]                           tgt,
   input  logic [CW-1:0]                           cnt,
   input  logic signed [slil_pkg::VALUE_W-1:0]     value,
   input  logic signed [slil_pkg::VALUE_W-1:0]     lower_data,
   input  logic signed [slil_pkg::VALUE_W-1:0]     upper_data,
   input  logic                                    found_in,
   output logic                                    found_out,
   output logic                                    first,
   output logic signed [slil_pkg::VALUE_W-1:0]     data
);

   localparam logic [CW:0] K = (CW+1)'(INDEX);

   logic signed [slil_pkg::VALUE_W-1:0] data_ff;
   logic signed [slil_pkg::VALUE_W-1:0] data_in;
   logic                                valid;
   logic [CW:0]                         tgt_x;
   logic [CW:0]                         cnt_x;

   assign tgt_x = {1'b0, tgt};
   assign cnt_x = {1'b0, cnt};
   assign valid = K < cnt_x;

   // first stored entry not less than the new value
   assign found_out = found_in | (valid & !(data_ff < value));
   assign first     = found_out & !found_in;
   assign data      = data_ff;

   always_comb begin
      data_in = data_ff;
      priority if (ctrl.ins) begin
         if (K == tgt_x) begin
            data_in = value;
         end else if (K > tgt_x && K <= cnt_x) begin
            data_in = lower_data;
         end
      end else if (ctrl.rem) begin
         if (K >= tgt_x && (K + 1'b1) < cnt_x) begin
            data_in = upper_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

>>> hw/rtl/sequential_list_insert_remove_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_insert_remove_unit: packed ordered list of signed words
// A row of CAPACITY cells that shift together on insert and remove.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command per beat (insert at position, sorted
//   insert, remove at position, read). rsp_chan returns exactly one result
//   beat per command with ok, read value, index used, count and the
//   empty/full flags after the command.
//   Latency: the result is presented the cycle after the command beat.
//   Throughput: one command per cycle while the result side does not stall;
//   every cell shifts and compares in parallel, so the update path is
//   bounded by the found-chain ripple through the row for sorted insert.
//   Reset: synchronous, active high; empties the list and drops any pending
//   result. Cell contents are not cleared, only the count.
//   Stall: the result register holds while rsp_chan.ready is low, and
//   req_chan.ready stays low until the held result is taken; a new command
//   is taken in the same cycle as the held result leaves.
//   Only positions 0..63 can be addressed; count and index_used are the low
//   bits of the internal values.
// ----------------------------------------------------------------------------
module sequential_list_insert_remove_unit #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   slil_req_if.sink         req_chan,
   slil_rsp_if.source       rsp_chan
);

   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int EW0 = (CW > slil_pkg::COUNT_OUT_W) ? CW : slil_pkg::COUNT_OUT_W;
   localparam int EW  = EW0;

   logic [CW-1:0]                        cnt_ff;
   logic [CW-1:0]                        cnt_in;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   slil_pkg::rsp_type                    rsp_ff;
   slil_pkg::rsp_type                    rsp_in;

   logic                                 accept;
   slil_pkg::req_type                    req;
   logic [EW-1:0]                        pos_x;
   logic [EW-1:0]                        cnt_x;
   logic                                 full;
   logic                                 ok;
   logic [CW-1:0]                        tgt;
   logic [CW-1:0]                        sort_idx;
   logic [EW-1:0]                        tgt_x;
   logic [EW-1:0]                        cnt_next_x;
   logic signed [slil_pkg::VALUE_W-1:0]  rd;
   slil_pkg::cell_ctrl_type              ctrl;

   logic [CAPACITY:0]                    found;
   logic [CAPACITY-1:0]                  first;
   logic signed [slil_pkg::VALUE_W-1:0]  cell_data [CAPACITY];

   assign req            = req_chan.data;
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign pos_x = EW'(req.position);
   assign cnt_x = EW'(cnt_ff);
   assign full  = cnt_ff == CW'(CAPACITY);

   // ---- row of cells ----
   assign found[0] = 1'b0;

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic signed [slil_pkg::VALUE_W-1:0] lower;
      logic signed [slil_pkg::VALUE_W-1:0] upper;

      if (k == 0) begin : g_lo
         assign lower = '0;
      end else begin : g_lo
         assign lower = cell_data[k-1];
      end
      if (k == CAPACITY - 1) begin : g_up
         assign upper = '0;
      end else begin : g_up
         assign upper = cell_data[k+1];
      end

      slil_cell #(
         .INDEX (k),
         .CW    (CW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .tgt        (tgt),
         .cnt        (cnt_ff),
         .value      (req.value),
         .lower_data (lower),
         .upper_data (upper),
         .found_in   (found[k]),
         .found_out  (found[k+1]),
         .first      (first[k]),
         .data       (cell_data[k])
      );
   end

   // encode the landing slot of a sorted insert; end of list if none found
   always_comb begin
      sort_idx = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         if (first[k]) begin
            sort_idx = sort_idx | CW'(k);
         end
      end
      if (!found[CAPACITY]) begin
         sort_idx = cnt_ff;
      end
   end

   // read mux: one-hot AND-OR over the cells
   always_comb begin
      rd = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         if (EW'(k) == pos_x) begin
            rd = rd | cell_data[k];
         end
      end
   end

   always_comb begin
      ok  = 1'b0;
      tgt = CW'(pos_x);
      unique case (req.cmd)
         slil_pkg::CMD_INSERT_AT: begin
            ok = !full && (pos_x <= cnt_x);
         end
         slil_pkg::CMD_INSERT_SORTED: begin
            ok  = !full;
            tgt = sort_idx;
         end
         slil_pkg::CMD_REMOVE,
         slil_pkg::CMD_READ: begin
            ok = pos_x < cnt_x;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      ctrl.ins = accept && ok &&
                 (req.cmd == slil_pkg::CMD_INSERT_AT ||
                  req.cmd == slil_pkg::CMD_INSERT_SORTED);
      ctrl.rem = accept && ok && (req.cmd == slil_pkg::CMD_REMOVE);
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (ctrl.ins) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (ctrl.rem) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   assign tgt_x      = EW'(tgt);
   assign cnt_next_x = EW'(cnt_in);

   always_comb begin
      rsp_in.ok         = ok;
      rsp_in.read_value = (ok && req.cmd == slil_pkg::CMD_READ) ? rd : '0;
      rsp_in.index_used = ok ? tgt_x[slil_pkg::POS_W-1:0] : '0;
      rsp_in.count      = cnt_next_x[slil_pkg::COUNT_OUT_W-1:0];
      rsp_in.is_empty   = cnt_in == '0;
      rsp_in.is_full    = cnt_in == CW'(CAPACITY);
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   // ---- checks ----
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_first_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first))
      else $error("more than one sorted-insert landing slot");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("count did not advance after insert");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ff.is_empty == (cnt_ff == '0))
      else $error("empty flag disagrees with count");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sequential_list_insert_remove_unit
// Drives list commands in bursts with random gaps while the result side
// stalls on its own pattern. A shadow copy of the list predicts every result
// beat, and each one is compared field by field.
// ----------------------------------------------------------------------------
module tb;

   localparam int CAPACITY     = 64;
   localparam int RANDOM_ITEMS = 1600;
   localparam int STALL_LIMIT  = 2000;

   typedef enum logic [1:0] {
      PH_GROW,
      PH_SHRINK,
      PH_MIXED
   } phase_type;

   logic clock;
   logic reset;

   slil_req_if req_bus ();
   slil_rsp_if rsp_bus ();

   sequential_list_insert_remove_unit #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shadow copy of the list
   logic signed [slil_pkg::VALUE_W-1:0] shadow_list [0:CAPACITY-1];
   int                                  shadow_count;
   slil_pkg::rsp_type                   due_rsp [$];

   int  fail_count;
   int  checked_beats;
   int  cmd_beats [4];
   int  rejected_beats;
   int  full_hits;
   int  burst_left;
   bit  sender_gaps_on;
   int  idle_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic slil_pkg::rsp_type update_shadow_list(input slil_pkg::req_type r);
      slil_pkg::rsp_type e;
      int                slot;
      int                k;
      e = '0;
      case (r.cmd)
         slil_pkg::CMD_INSERT_AT, slil_pkg::CMD_INSERT_SORTED: begin
            if (r.cmd == slil_pkg::CMD_INSERT_AT) begin
               slot = int'(r.position);
            end else begin
               slot = 0;
               while (slot < shadow_count && shadow_list[slot] < $signed(r.value))
                  slot++;
            end
            if (shadow_count < CAPACITY && slot <= shadow_count) begin
               for (k = shadow_count; k > slot; k--)
                  shadow_list[k] = shadow_list[k-1];
               shadow_list[slot] = r.value;
               shadow_count++;
               e.ok         = 1'b1;
               e.index_used = slot[slil_pkg::POS_W-1:0];
            end
         end
         slil_pkg::CMD_REMOVE: begin
            if (shadow_count > 0 && int'(r.position) < shadow_count) begin
               for (k = int'(r.position); k + 1 < shadow_count; k++)
                  shadow_list[k] = shadow_list[k+1];
               shadow_count--;
               e.ok         = 1'b1;
               e.index_used = r.position;
            end
         end
         default: begin
            if (int'(r.position) < shadow_count) begin
               e.read_value = shadow_list[r.position];
               e.ok         = 1'b1;
               e.index_used = r.position;
            end
         end
      endcase
      e.count    = shadow_count[slil_pkg::COUNT_OUT_W-1:0];
      e.is_empty = (shadow_count == 0);
      e.is_full  = (shadow_count == CAPACITY);
      return e;
   endfunction

   // one command beat; the sender runs in bursts separated by idle gaps
   task automatic send_cmd(input slil_pkg::cmd_type c,
                           input logic signed [slil_pkg::VALUE_W-1:0] v,
                           input logic [slil_pkg::POS_W-1:0] p);
      slil_pkg::req_type beat;
      slil_pkg::rsp_type e;
      int                gap;
      beat = '{cmd: c, value: v, position: p};
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.data  <= beat;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      e = update_shadow_list(beat);
      due_rsp.push_back(e);
      cmd_beats[c]++;
      if (!e.ok)
         rejected_beats++;
      if (e.is_full)
         full_hits++;
   endtask

   task automatic check_field(input string name,
                              input logic [slil_pkg::VALUE_W-1:0] exp_v,
                              input logic [slil_pkg::VALUE_W-1:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s expected %h, got %h", $realtime, name, exp_v, got_v);
         fail_count++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      slil_pkg::rsp_type exp_r;
      slil_pkg::rsp_type got_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_r = rsp_bus.data;
         if (due_rsp.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got %h",
                     $realtime, got_r);
            fail_count++;
         end else begin
            exp_r = due_rsp.pop_front();
            check_field("ok", 32'(exp_r.ok), 32'(got_r.ok));
            check_field("read_value", exp_r.read_value, got_r.read_value);
            check_field("index_used", 32'(exp_r.index_used), 32'(got_r.index_used));
            check_field("count", 32'(exp_r.count), 32'(got_r.count));
            check_field("is_empty", 32'(exp_r.is_empty), 32'(got_r.is_empty));
            check_field("is_full", 32'(exp_r.is_full), 32'(got_r.is_full));
            checked_beats++;
         end
      end
   end

   // result side back-pressure: free-running, rotating or random pattern
   initial begin
      logic [15:0] stall_pat;
      int          mode;
      int          mode_left;
      rsp_bus.ready = 1'b0;
      stall_pat     = 16'h1;
      mode          = 0;
      mode_left     = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode_left = $urandom_range(64, 200);
            mode      = $urandom_range(0, 2);
            stall_pat = 16'($urandom) | 16'h1;
         end
         mode_left--;
         case (mode)
            0: rsp_bus.ready <= 1'b1;
            1: begin
               stall_pat = {stall_pat[14:0], stall_pat[15]};
               rsp_bus.ready <= stall_pat[0];
            end
            default: rsp_bus.ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
         $display("sequential_list_insert_remove_unit: mismatch");
         $finish;
      end
   end

   task automatic test_empty_list();
      send_cmd(slil_pkg::CMD_READ, 32'sd0, 6'd0);
      send_cmd(slil_pkg::CMD_READ, 32'sd7, 6'd63);
      send_cmd(slil_pkg::CMD_REMOVE, 32'sd0, 6'd0);
      send_cmd(slil_pkg::CMD_INSERT_AT, 32'sd9, 6'd1);   // position beyond count
   endtask

   task automatic test_directed_edges();
      send_cmd(slil_pkg::CMD_INSERT_AT, 32'sh7fffffff, 6'd0);
      send_cmd(slil_pkg::CMD_INSERT_SORTED, 32'sh80000000, 6'd63);
      send_cmd(slil_pkg::CMD_INSERT_SORTED, 32'sd0, 6'd0);
      send_cmd(slil_pkg::CMD_INSERT_SORTED, 32'sd0, 6'd0);          // tie goes first
      send_cmd(slil_pkg::CMD_INSERT_SORTED, 32'sh7fffffff, 6'd0);   // tie with max
      send_cmd(slil_pkg::CMD_INSERT_AT, -32'sd1, 6'd5);             // append at count
      send_cmd(slil_pkg::CMD_INSERT_AT, 32'sd3, 6'd7);
      send_cmd(slil_pkg::CMD_INSERT_AT, 32'sd3, 6'd63);
      send_cmd(slil_pkg::CMD_READ, 32'sd0, 6'd0);
      send_cmd(slil_pkg::CMD_READ, 32'sd0, 6'd5);
      send_cmd(slil_pkg::CMD_READ, 32'sd0, 6'd6);
      send_cmd(slil_pkg::CMD_READ, 32'sd0, 6'd63);
      send_cmd(slil_pkg::CMD_REMOVE, 32'sd0, 6'd6);
      send_cmd(slil_pkg::CMD_REMOVE, 32'sd0, 6'd63);
      send_cmd(slil_pkg::CMD_REMOVE, 32'sd0, 6'd0);
      send_cmd(slil_pkg::CMD_REMOVE, 32'sd0, 6'd4);                 // last entry
      send_cmd(slil_pkg::CMD_REMOVE, 32'sd0, 6'd1);
      send_cmd(slil_pkg::CMD_INSERT_AT, 32'sh55555555, 6'd0);
      send_cmd(slil_pkg::CMD_INSERT_AT, 32'shaaaaaaaa, 6'd1);
      send_cmd(slil_pkg::CMD_READ, 32'sd0, 6'd1);
   endtask

   task automatic random_cmd(input phase_type ph);
      slil_pkg::cmd_type                   c;
      logic signed [slil_pkg::VALUE_W-1:0] v;
      logic [slil_pkg::POS_W-1:0]          p;
      int                                  roll;
      int                                  top;
      roll = $urandom_range(0, 99);
      case (ph)
         PH_GROW:
            c = (roll < 45) ? slil_pkg::CMD_INSERT_SORTED :
                (roll < 75) ? slil_pkg::CMD_INSERT_AT :
                (roll < 88) ? slil_pkg::CMD_READ : slil_pkg::CMD_REMOVE;
         PH_SHRINK:
            c = (roll < 55) ? slil_pkg::CMD_REMOVE :
                (roll < 75) ? slil_pkg::CMD_READ :
                (roll < 88) ? slil_pkg::CMD_INSERT_SORTED : slil_pkg::CMD_INSERT_AT;
         default:
            c = slil_pkg::cmd_type'(roll % 4);
      endcase
      // mostly in-range positions, some anywhere in the field
      if ($urandom_range(0, 9) < 7) begin
         if (c == slil_pkg::CMD_INSERT_AT)
            top = (shadow_count < CAPACITY - 1) ? shadow_count : CAPACITY - 1;
         else
            top = (shadow_count > 0) ? shadow_count - 1 : 0;
         p = slil_pkg::POS_W'($urandom_range(0, top));
      end else begin
         p = slil_pkg::POS_W'($urandom_range(0, 63));
      end
      roll = $urandom_range(0, 99);
      if (roll < 45)
         v = $urandom;
      else if (roll < 65)
         v = $signed($urandom_range(0, 4)) - 32'sd2;
      else if (roll < 85 && shadow_count > 0)
         v = shadow_list[$urandom_range(0, shadow_count - 1)];   // force ties
      else if (roll < 92)
         v = 32'sh7fffffff;
      else if (roll < 96)
         v = 32'sh80000000;
      else
         v = $urandom;
      send_cmd(c, v, p);
   endtask

   task automatic test_random_grow_shrink();
      int sent;
      int n;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         n = 0;
         while (shadow_count < CAPACITY && n < 400) begin
            random_cmd(PH_GROW);
            n++;
         end
         repeat (8) random_cmd(PH_GROW);   // keep pushing while full
         sent += n + 8;
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         repeat (150) random_cmd(PH_MIXED);
         sent += 150;
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         n = 0;
         while (shadow_count > 0 && n < 400) begin
            random_cmd(PH_SHRINK);
            n++;
         end
         repeat (4) random_cmd(PH_SHRINK);  // removes and reads rejected on the empty list
         sent += n + 4;
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.data   = '0;
      shadow_count   = 0;
      fail_count     = 0;
      checked_beats  = 0;
      rejected_beats = 0;
      full_hits      = 0;
      burst_left     = 0;
      sender_gaps_on = 1'b1;
      foreach (cmd_beats[i])
         cmd_beats[i] = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_directed_edges();
      test_random_grow_shrink();

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (due_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      $display("checked %0d result beats: %0d insert-at, %0d sorted insert,",
               checked_beats, cmd_beats[slil_pkg::CMD_INSERT_AT],
               cmd_beats[slil_pkg::CMD_INSERT_SORTED]);
      $display("%0d remove, %0d read; %0d rejected by bounds, %0d with the list full",
               cmd_beats[slil_pkg::CMD_REMOVE], cmd_beats[slil_pkg::CMD_READ],
               rejected_beats, full_hits);
      if (fail_count == 0 && due_rsp.size() == 0) begin
         $display("sequential_list_insert_remove_unit: match");
      end else begin
         $display("sequential_list_insert_remove_unit: mismatch");
      end
      $finish;
   end

endmodule
